// ===== src/cite_pkg.sv =====
// ----------------------------------------------------------------------------
// cite_pkg: shared types, constants and mnemonic tables
// Character buffer sizes, separator codes and the comp, dest and jump
// mnemonic tables used by the C-instruction text encoder.
// ----------------------------------------------------------------------------
package cite_pkg;

   // characters kept for each part of the instruction text
   localparam int MnemonicChars = 3;
   localparam int ChrW          = 8 * MnemonicChars;
   // count saturates at MnemonicChars + 1 to mark a part as too long
   localparam int CntW          = $clog2(MnemonicChars + 2);

   localparam logic [7:0] CharEq   = 8'h3D;   // '='
   localparam logic [7:0] CharSemi = 8'h3B;   // ';'

   localparam logic [CntW-1:0] CountFull = CntW'(MnemonicChars);
   localparam logic [CntW-1:0] CountOver = CntW'(MnemonicChars + 1);

   typedef enum logic [1:0] {
      SepNone = 2'd0,
      SepEq   = 2'd1,
      SepSemi = 2'd2
   } sep_type;

   // snapshot of both parts after the current character is taken in
   typedef struct packed {
      logic [ChrW-1:0] front_chars;
      logic [CntW-1:0] front_count;
      logic [ChrW-1:0] back_chars;
      logic [CntW-1:0] back_count;
      sep_type         sep;
   } parts_type;

   // one mnemonic: text right-justified, first character in the highest used byte
   typedef struct packed {
      logic [31:0] text;
      logic [1:0]  len;
      logic [6:0]  code;
   } mnem_type;

   typedef struct packed {
      logic       hit;
      logic [6:0] code;
   } hit_type;

   localparam mnem_type CompTable [28] = '{
      '{"0",   2'd1, 7'h2A}, '{"1",   2'd1, 7'h3F}, '{"-1",  2'd2, 7'h3A},
      '{"D",   2'd1, 7'h0C}, '{"A",   2'd1, 7'h30}, '{"M",   2'd1, 7'h70},
      '{"!D",  2'd2, 7'h0D}, '{"!A",  2'd2, 7'h31}, '{"!M",  2'd2, 7'h71},
      '{"-D",  2'd2, 7'h0F}, '{"-A",  2'd2, 7'h33}, '{"-M",  2'd2, 7'h73},
      '{"D+1", 2'd3, 7'h1F}, '{"A+1", 2'd3, 7'h37}, '{"M+1", 2'd3, 7'h77},
      '{"D-1", 2'd3, 7'h0E}, '{"A-1", 2'd3, 7'h32}, '{"M-1", 2'd3, 7'h72},
      '{"D+A", 2'd3, 7'h02}, '{"D+M", 2'd3, 7'h42}, '{"D-A", 2'd3, 7'h13},
      '{"D-M", 2'd3, 7'h53}, '{"A-D", 2'd3, 7'h07}, '{"M-D", 2'd3, 7'h47},
      '{"D&A", 2'd3, 7'h00}, '{"D&M", 2'd3, 7'h40}, '{"D|A", 2'd3, 7'h15},
      '{"D|M", 2'd3, 7'h55}
   };

   localparam mnem_type DestTable [7] = '{
      '{"M",   2'd1, 7'd1}, '{"D",   2'd1, 7'd2}, '{"DM",  2'd2, 7'd3},
      '{"A",   2'd1, 7'd4}, '{"AM",  2'd2, 7'd5}, '{"AD",  2'd2, 7'd6},
      '{"ADM", 2'd3, 7'd7}
   };

   localparam mnem_type JumpTable [7] = '{
      '{"JGT", 2'd3, 7'd1}, '{"JEQ", 2'd3, 7'd2}, '{"JGE", 2'd3, 7'd3},
      '{"JLT", 2'd3, 7'd4}, '{"JNE", 2'd3, 7'd5}, '{"JLE", 2'd3, 7'd6},
      '{"JMP", 2'd3, 7'd7}
   };

   // exact match of a stored part against one mnemonic
   function automatic logic part_match(logic [ChrW-1:0] chars, logic [CntW-1:0] count,
                                       mnem_type m);
      logic       ok;
      logic [1:0] j;
      ok = (count == CntW'(m.len));
      for (int i = 0; i < 3; i++) begin
         j = m.len - 2'(i) - 2'd1;
         if (2'(i) < m.len) begin
            ok = ok && (chars[8*i +: 8] == m.text[8*j +: 8]);
         end
      end
      return ok;
   endfunction

   function automatic hit_type comp_lookup(logic [ChrW-1:0] chars, logic [CntW-1:0] count);
      hit_type r;
      r = '0;
      for (int k = 27; k >= 0; k--) begin
         if (part_match(chars, count, CompTable[k])) begin
            r = '{hit: 1'b1, code: CompTable[k].code};
         end
      end
      return r;
   endfunction

   function automatic hit_type dest_lookup(logic [ChrW-1:0] chars, logic [CntW-1:0] count);
      hit_type r;
      r = '0;
      for (int k = 6; k >= 0; k--) begin
         if (part_match(chars, count, DestTable[k])) begin
            r = '{hit: 1'b1, code: DestTable[k].code};
         end
      end
      return r;
   endfunction

   function automatic hit_type jump_lookup(logic [ChrW-1:0] chars, logic [CntW-1:0] count);
      hit_type r;
      r = '0;
      for (int k = 6; k >= 0; k--) begin
         if (part_match(chars, count, JumpTable[k])) begin
            r = '{hit: 1'b1, code: JumpTable[k].code};
         end
      end
      return r;
   endfunction

endpackage

// ===== src/cite_collect.sv =====
// ----------------------------------------------------------------------------
// cite_collect: front and back part buffers
// Splits the character stream at the first separator and keeps up to
// MnemonicChars characters of each part; cleared after the last character.
// ----------------------------------------------------------------------------
module cite_collect (
   input  logic                clock,
   input  logic                reset,
   input  logic                step,       // a character is taken in this cycle
   input  logic [7:0]          char_code,
   input  logic                last,
   output cite_pkg::parts_type parts       // state including this character
);

   logic [cite_pkg::ChrW-1:0] front_chars_ff, front_chars_in;
   logic [cite_pkg::CntW-1:0] front_count_ff, front_count_in;
   logic [cite_pkg::ChrW-1:0] back_chars_ff,  back_chars_in;
   logic [cite_pkg::CntW-1:0] back_count_ff,  back_count_in;
   cite_pkg::sep_type         sep_ff,         sep_in;

   // next part contents for this character
   always_comb begin
      front_chars_in = front_chars_ff;
      front_count_in = front_count_ff;
      back_chars_in  = back_chars_ff;
      back_count_in  = back_count_ff;
      sep_in         = sep_ff;
      if (sep_ff == cite_pkg::SepNone) begin
         if (char_code == cite_pkg::CharEq) begin
            sep_in = cite_pkg::SepEq;
         end else if (char_code == cite_pkg::CharSemi) begin
            sep_in = cite_pkg::SepSemi;
         end else if (front_count_ff < cite_pkg::CountFull) begin
            for (int k = 0; k < cite_pkg::MnemonicChars; k++) begin
               if (front_count_ff == cite_pkg::CntW'(k)) begin
                  front_chars_in[8*k +: 8] = char_code;
               end
            end
            front_count_in = front_count_ff + 1'b1;
         end else begin
            front_count_in = cite_pkg::CountOver;
         end
      end else if (back_count_ff < cite_pkg::CountFull) begin
         for (int k = 0; k < cite_pkg::MnemonicChars; k++) begin
            if (back_count_ff == cite_pkg::CntW'(k)) begin
               back_chars_in[8*k +: 8] = char_code;
            end
         end
         back_count_in = back_count_ff + 1'b1;
      end else begin
         back_count_in = cite_pkg::CountOver;
      end
   end

   assign parts = '{front_chars: front_chars_in, front_count: front_count_in,
                    back_chars: back_chars_in, back_count: back_count_in,
                    sep: sep_in};

   // part registers, emptied after each instruction
   always_ff @(posedge clock) begin
      if (reset || (step && last)) begin
         front_chars_ff <= '0;
         front_count_ff <= '0;
         back_chars_ff  <= '0;
         back_count_ff  <= '0;
         sep_ff         <= cite_pkg::SepNone;
      end else if (step) begin
         front_chars_ff <= front_chars_in;
         front_count_ff <= front_count_in;
         back_chars_ff  <= back_chars_in;
         back_count_ff  <= back_count_in;
         sep_ff         <= sep_in;
      end
   end

   // buffers are empty once an instruction has ended
   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      step && last |=> front_count_ff == '0 && back_count_ff == '0 &&
                       sep_ff == cite_pkg::SepNone)
      else $error("part buffers not cleared after last word");

   // back part only fills once a separator has been seen
   a_back_needs_sep: assert property (@(posedge clock) disable iff (reset)
      back_count_ff != '0 |-> sep_ff != cite_pkg::SepNone)
      else $error("back part filled without separator");

endmodule

// ===== src/cite_encode.sv =====
// ----------------------------------------------------------------------------
// cite_encode: mnemonic lookup and word assembly
// Matches the parts against the comp, dest and jump tables and builds the
// 16-bit machine word and the error flag.
// ----------------------------------------------------------------------------
module cite_encode (
   input  cite_pkg::parts_type parts,
   output logic [15:0]         machine_word,
   output logic                bad_instruction
);

   cite_pkg::hit_type comp_hit;
   cite_pkg::hit_type dest_hit;
   cite_pkg::hit_type jump_hit;

   // role of each part follows the separator
   always_comb begin
      comp_hit = '0;
      dest_hit = '0;
      jump_hit = '0;
      unique case (parts.sep)
         cite_pkg::SepEq: begin
            dest_hit = cite_pkg::dest_lookup(parts.front_chars, parts.front_count);
            comp_hit = cite_pkg::comp_lookup(parts.back_chars, parts.back_count);
         end
         cite_pkg::SepSemi: begin
            comp_hit = cite_pkg::comp_lookup(parts.front_chars, parts.front_count);
            jump_hit = cite_pkg::jump_lookup(parts.back_chars, parts.back_count);
         end
         default: begin
            comp_hit = '0;
         end
      endcase
   end

   // unknown dest or jump encodes as zero; unknown comp flags an error
   assign bad_instruction = !comp_hit.hit;
   assign machine_word    = bad_instruction ? 16'h0000 :
                            {3'b111, comp_hit.code, dest_hit.code[2:0], jump_hit.code[2:0]};

endmodule

// ===== src/c_instruction_text_encoder.sv =====
// Path: an accepted character word waits in the input register, then enters the part
//   buffers; an instruction's last one loads the result register and raises rsp_tvalid.
// Throughput: one character word per cycle, limited only by rsp back-pressure on the
//   last character of an instruction.
// Reset: synchronous; empties the input stage, the part buffers and the result register.
// ----------------------------------------------------------------------------
// c_instruction_text_encoder: top level
// Input register, part collector, mnemonic encoder and result register for
// streaming C-instruction text into 16-bit machine words.
// ----------------------------------------------------------------------------
module c_instruction_text_encoder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] char_code
   input  logic        req_tlast,   // end_of_text
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [15:0] machine_word
   output logic        rsp_tuser    // [0] bad_instruction
);

   logic                in_valid_ff, in_valid_in;
   logic [7:0]          in_char_ff;
   logic                in_last_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [15:0]         rsp_word_ff;
   logic                rsp_bad_ff;
   logic                advance;
   logic                load;
   cite_pkg::parts_type parts;
   logic [15:0]         enc_word;
   logic                enc_bad;

   // a held word moves on unless it is the last one and the result slot is blocked
   assign advance     = in_valid_ff && (!in_last_ff || !rsp_valid_ff || rsp_tready);
   assign load        = advance && in_last_ff;
   assign req_tready  = !in_valid_ff || advance;
   assign in_valid_in = req_tready ? req_tvalid : in_valid_ff;

   always_comb begin
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // input stage
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_char_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
   end

   cite_collect u_collect (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .char_code (in_char_ff),
      .last      (in_last_ff),
      .parts     (parts)
   );

   cite_encode u_encode (
      .parts           (parts),
      .machine_word    (enc_word),
      .bad_instruction (enc_bad)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_word_ff <= enc_word;
         rsp_bad_ff  <= enc_bad;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_word_ff;
   assign rsp_tuser  = rsp_bad_ff;

   // a flagged result carries an all-zero word, a good one the 111 prefix
   a_word_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_bad_ff && rsp_word_ff == 16'h0000) ||
                       (!rsp_bad_ff && rsp_word_ff[15:13] == 3'b111))
      else $error("result word has wrong form");

   // a result is never overwritten while it still waits
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_tready |-> !load)
      else $error("waiting result overwritten");

   // a stalled input word stays put
   a_in_hold: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_char_ff) && $stable(in_last_ff))
      else $error("stalled input word lost");

endmodule
